@@ sv/thc_pkg.sv @@
// Shared types, constants and helpers for the temperature/humidity compensation block.
// No dependencies; every other file refers to this package by scoped names.
package thc_pkg;

	localparam int NUM_STAGES = 16;

	localparam int IN_W  = 40;
	localparam int OUT_W = 72;
	localparam int CFG_W = 24;

	// Compensation constants
	localparam logic [31:0] FINE_OFFSET = 32'd76800;
	localparam logic [31:0] HUM_ROUND   = 32'd16384;
	localparam logic [31:0] HUM_MID     = 32'd32768;
	localparam logic [31:0] HUM_BIAS    = 32'd2097152;
	localparam logic [31:0] GAIN_ROUND  = 32'd8192;
	localparam logic [31:0] CENTI_ROUND = 32'd128;
	localparam logic signed [31:0] HUM_MAX   = 32'sd419430400;
	localparam logic signed [31:0] CENTI_MAX = 32'sd32767;
	localparam logic signed [31:0] CENTI_MIN = -32'sd32768;

	typedef enum logic [2:0] {
		REG_TEMP_TRIM_ONE   = 3'd0,
		REG_TEMP_TRIM_TWO   = 3'd1,
		REG_TEMP_TRIM_THREE = 3'd2,
		REG_HUM_TRIM_ONE    = 3'd3,
		REG_HUM_TRIM_TWO    = 3'd4,
		REG_HUM_TRIM_THREE  = 3'd5,
		REG_HUM_TRIM_45     = 3'd6,
		REG_HUM_TRIM_SIX    = 3'd7
	} cfg_reg_e;

	// Trim words, already sign or zero extended to 32 bits
	typedef struct packed {
		logic [31:0] t1;
		logic [31:0] t2;
		logic [31:0] t3;
		logic [31:0] h1;
		logic [31:0] h2;
		logic [31:0] h3;
		logic [31:0] h4;
		logic [31:0] h5;
		logic [31:0] h6;
	} trim_t;

	// Per-stage load strobes from the pipeline control
	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
	} stage_ctl_t;

	function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
		return $unsigned($signed(x) >>> n);
	endfunction

endpackage

@@ sv/thc_ctrl.sv @@
// Valid/ready control for the compensation pipeline: one valid bit per stage.
// A stage loads when it is empty or the stage after it moves. Uses thc_pkg.
module thc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output thc_pkg::stage_ctl_t ctl
);

	logic [thc_pkg::NUM_STAGES-1:0] vld_q;
	logic [thc_pkg::NUM_STAGES:0]   rdy;
	logic [thc_pkg::NUM_STAGES-1:0] vin;

	always_comb begin
		rdy[thc_pkg::NUM_STAGES] = out_ready;
		for (int k = thc_pkg::NUM_STAGES - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
		vin = {vld_q[thc_pkg::NUM_STAGES-2:0], in_valid};
		ctl.load = rdy[thc_pkg::NUM_STAGES-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < thc_pkg::NUM_STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vin[k];
				end
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_q[thc_pkg::NUM_STAGES-1];

endmodule

@@ sv/thc_temp.sv @@
// Temperature half of the pipeline, stages 1 to 6: fine temperature and
// saturated centidegrees; also forms the humidity offset term. Uses thc_pkg.
module thc_temp (
	input  logic                clk,
	input  thc_pkg::stage_ctl_t ctl,
	input  thc_pkg::trim_t      trim,
	input  logic [19:0]         raw_temperature,
	input  logic [15:0]         raw_humidity,
	output logic [31:0]         v_s5,
	output logic [15:0]         raw_hum_s5,
	output logic [31:0]         fine_s6,
	output logic [15:0]         centi_s6
);

	logic [31:0] x1_s1, d_s1, m1_s2, dd_s2, p1_s3, m2_s3, fine_s4;
	logic [31:0] fine_s5, tc_s5;
	logic [15:0] rh_s1, rh_s2, rh_s3, rh_s4;
	logic [31:0] tsh;

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			x1_s1 <= 32'(raw_temperature >> 3) - {15'd0, trim.t1[15:0], 1'b0};
			d_s1  <= 32'(raw_temperature >> 4) - trim.t1;
			rh_s1 <= raw_humidity;
		end
		if (ctl.load[1]) begin
			m1_s2 <= x1_s1 * trim.t2;
			dd_s2 <= d_s1 * d_s1;
			rh_s2 <= rh_s1;
		end
		if (ctl.load[2]) begin
			p1_s3 <= thc_pkg::asr32(m1_s2, 5'd11);
			m2_s3 <= thc_pkg::asr32(dd_s2, 5'd12) * trim.t3;
			rh_s3 <= rh_s2;
		end
		if (ctl.load[3]) begin
			fine_s4 <= p1_s3 + thc_pkg::asr32(m2_s3, 5'd14);
			rh_s4   <= rh_s3;
		end
		if (ctl.load[4]) begin
			fine_s5    <= fine_s4;
			tc_s5      <= fine_s4 * 32'd5 + thc_pkg::CENTI_ROUND;
			v_s5       <= fine_s4 - thc_pkg::FINE_OFFSET;
			raw_hum_s5 <= rh_s4;
		end
		if (ctl.load[5]) begin
			fine_s6 <= fine_s5;
			if ($signed(tsh) > thc_pkg::CENTI_MAX) begin
				centi_s6 <= 16'(thc_pkg::CENTI_MAX);
			end else if ($signed(tsh) < thc_pkg::CENTI_MIN) begin
				centi_s6 <= 16'(thc_pkg::CENTI_MIN);
			end else begin
				centi_s6 <= tsh[15:0];
			end
		end
	end

	assign tsh = thc_pkg::asr32(tc_s5, 5'd8);

endmodule

@@ sv/thc_hum.sv @@
// Humidity half of the pipeline, stages 6 to 16: up to three multiplies per stage,
// then clamp and scale to unsigned Q7.10 with the low 12 bits dropped. Uses thc_pkg.
module thc_hum (
	input  logic                clk,
	input  thc_pkg::stage_ctl_t ctl,
	input  thc_pkg::trim_t      trim,
	input  logic [31:0]         v_s5,
	input  logic [15:0]         raw_hum_s5,
	output logic [16:0]         hum_s16
);

	logic [31:0] hv5_s6, v6_s6, v3_s6, apre_s6;
	logic [31:0] a_s7, c_s7, e_s7;
	logic [31:0] a_s8, b_s8;
	logic [31:0] a_s9, b_s9;
	logic [31:0] a_s10, mb_s10;
	logic [31:0] a_s11, b_s11;
	logic [31:0] v_s12;
	logic [31:0] v_s13, sq_s13;
	logic [31:0] v_s14, qm_s14;
	logic [31:0] hv_s15;
	logic [31:0] s12;

	assign s12 = thc_pkg::asr32(v_s12, 5'd15);

	always_ff @(posedge clk) begin
		if (ctl.load[5]) begin
			hv5_s6  <= trim.h5 * v_s5;
			v6_s6   <= v_s5 * trim.h6;
			v3_s6   <= v_s5 * trim.h3;
			apre_s6 <= {2'd0, raw_hum_s5, 14'd0} - {trim.h4[11:0], 20'd0}
				+ thc_pkg::HUM_ROUND;
		end
		if (ctl.load[6]) begin
			a_s7 <= thc_pkg::asr32(apre_s6 - hv5_s6, 5'd15);
			c_s7 <= thc_pkg::asr32(v3_s6, 5'd11) + thc_pkg::HUM_MID;
			e_s7 <= thc_pkg::asr32(v6_s6, 5'd10);
		end
		if (ctl.load[7]) begin
			a_s8 <= a_s7;
			b_s8 <= e_s7 * c_s7;
		end
		if (ctl.load[8]) begin
			a_s9 <= a_s8;
			b_s9 <= thc_pkg::asr32(b_s8, 5'd10) + thc_pkg::HUM_BIAS;
		end
		if (ctl.load[9]) begin
			a_s10  <= a_s9;
			mb_s10 <= b_s9 * trim.h2;
		end
		if (ctl.load[10]) begin
			a_s11 <= a_s10;
			b_s11 <= thc_pkg::asr32(mb_s10 + thc_pkg::GAIN_ROUND, 5'd14);
		end
		if (ctl.load[11]) begin
			v_s12 <= a_s11 * b_s11;
		end
		if (ctl.load[12]) begin
			v_s13  <= v_s12;
			sq_s13 <= s12 * s12;
		end
		if (ctl.load[13]) begin
			v_s14  <= v_s13;
			qm_s14 <= thc_pkg::asr32(sq_s13, 5'd7) * trim.h1;
		end
		if (ctl.load[14]) begin
			hv_s15 <= v_s14 - thc_pkg::asr32(qm_s14, 5'd4);
		end
		if (ctl.load[15]) begin
			if ($signed(hv_s15) < 32'sd0) begin
				hum_s16 <= '0;
			end else if ($signed(hv_s15) > thc_pkg::HUM_MAX) begin
				hum_s16 <= 17'(thc_pkg::HUM_MAX >>> 12);
			end else begin
				hum_s16 <= hv_s15[28:12];
			end
		end
	end

endmodule

@@ sv/temp_humidity_compensation.sv @@
// Top level of the temperature/humidity compensation block: trim registers,
// pipeline control, temperature and humidity datapaths. Uses thc_pkg.
//
//  channel   | dir | beat contents (tdata, low bits first)
//  s_axis    | in  | raw_temperature[19:0], raw_humidity[35:20], zero pad to 40
//  m_axis    | out | fine_temperature[31:0], temperature_centi[47:32],
//            |     | humidity_q10[64:48], zero pad to 72
//  cfg       | in  | cfg_we, cfg_index (register 0..7), cfg_data (24 bits)
//
// Sixteen register stages, at most three 32-bit multiplies per stage; one beat
// per cycle is sustained while m_axis_tready stays high.
// Each stage has its own valid bit and loads when empty or when the next
// stage moves, so a stalled output still lets bubbles fill.
// Reset clears the valid bits and the trim registers to zero.
module temp_humidity_compensation (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// raw_temperature, raw_humidity, pad
	input  logic [thc_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// fine_temperature, temperature_centi, humidity_q10, pad
	output logic [thc_pkg::OUT_W-1:0] m_axis_tdata,
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_index,
	input  logic [thc_pkg::CFG_W-1:0] cfg_data
);

	logic [15:0] t1_q, t2_q, t3_q, h2_q;
	logic [7:0]  h1_q, h3_q, h6_q;
	logic [23:0] h45_q;

	thc_pkg::trim_t     trim;
	thc_pkg::stage_ctl_t ctl;
	thc_pkg::cfg_reg_e   cfg_sel;

	logic [31:0] v_s5, fine_s6;
	logic [15:0] raw_hum_s5, centi_s6;
	logic [16:0] hum_s16;

	// fine and centi ride alongside the humidity stages 7..16
	logic [31:0] fine_sn  [7:16];
	logic [15:0] centi_sn [7:16];

	assign cfg_sel = thc_pkg::cfg_reg_e'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q  <= '0;
			t2_q  <= '0;
			t3_q  <= '0;
			h1_q  <= '0;
			h2_q  <= '0;
			h3_q  <= '0;
			h45_q <= '0;
			h6_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_sel)
				thc_pkg::REG_TEMP_TRIM_ONE:   t1_q  <= cfg_data[15:0];
				thc_pkg::REG_TEMP_TRIM_TWO:   t2_q  <= cfg_data[15:0];
				thc_pkg::REG_TEMP_TRIM_THREE: t3_q  <= cfg_data[15:0];
				thc_pkg::REG_HUM_TRIM_ONE:    h1_q  <= cfg_data[7:0];
				thc_pkg::REG_HUM_TRIM_TWO:    h2_q  <= cfg_data[15:0];
				thc_pkg::REG_HUM_TRIM_THREE:  h3_q  <= cfg_data[7:0];
				thc_pkg::REG_HUM_TRIM_45:     h45_q <= cfg_data;
				thc_pkg::REG_HUM_TRIM_SIX:    h6_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		trim.t1 = {16'd0, t1_q};
		trim.t2 = {{16{t2_q[15]}}, t2_q};
		trim.t3 = {{16{t3_q[15]}}, t3_q};
		trim.h1 = {24'd0, h1_q};
		trim.h2 = {{16{h2_q[15]}}, h2_q};
		trim.h3 = {24'd0, h3_q};
		trim.h4 = {{20{h45_q[23]}}, h45_q[23:12]};
		trim.h5 = {{20{h45_q[11]}}, h45_q[11:0]};
		trim.h6 = {{24{h6_q[7]}}, h6_q};
	end

	thc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.ctl       (ctl)
	);

	thc_temp u_temp (
		.clk             (clk),
		.ctl             (ctl),
		.trim            (trim),
		.raw_temperature (s_axis_tdata[19:0]),
		.raw_humidity    (s_axis_tdata[35:20]),
		.v_s5            (v_s5),
		.raw_hum_s5      (raw_hum_s5),
		.fine_s6         (fine_s6),
		.centi_s6        (centi_s6)
	);

	thc_hum u_hum (
		.clk        (clk),
		.ctl        (ctl),
		.trim       (trim),
		.v_s5       (v_s5),
		.raw_hum_s5 (raw_hum_s5),
		.hum_s16    (hum_s16)
	);

	always_ff @(posedge clk) begin
		if (ctl.load[6]) begin
			fine_sn[7]  <= fine_s6;
			centi_sn[7] <= centi_s6;
		end
		for (int k = 8; k <= 16; k++) begin
			if (ctl.load[k-1]) begin
				fine_sn[k]  <= fine_sn[k-1];
				centi_sn[k] <= centi_sn[k-1];
			end
		end
	end

	assign m_axis_tdata = {7'd0, hum_s16, centi_sn[16], fine_sn[16]};

endmodule
